### rtl/filsq_pkg.sv
`default_nettype none
package filsq_pkg;
  localparam int unsigned W = 64;
  localparam logic [W-1:0] PRIME     = 64'hFFFFFFFFFFFFFFC5;
  localparam logic [W-1:0] UNITY_M   = 64'h000000000000003B;
  localparam logic [W-1:0] MONT_R2   = 64'h0000000000000D99;
  localparam logic [W-1:0] PSI       = 64'h57F56382B3D1DEF4;
  localparam logic [W-1:0] EXP_INV   = 64'hFFFFFFFFFFFFFFC3;
  localparam logic [W-1:0] EXP_LEG   = 64'h7FFFFFFFFFFFFFE2;
  localparam logic [W-1:0] EXP_QUART = 64'h3FFFFFFFFFFFFFF1;
  localparam logic [W-1:0] EXP_ROOT  = 64'h1FFFFFFFFFFFFFF9;
  localparam logic [7:0]   LEG_MASK  = 8'h80;

  localparam logic [2:0] FN_INV   = 3'd0;
  localparam logic [2:0] FN_LEG   = 3'd1;
  localparam logic [2:0] FN_SQRT  = 3'd2;
  localparam logic [2:0] FN_TOM   = 3'd3;
  localparam logic [2:0] FN_FROMM = 3'd4;

  typedef logic [W-1:0] elem_t;
endpackage
`default_nettype wire

### rtl/filsq_if.sv
`default_nettype none
interface filsq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [63:0] operand;
  modport source (output valid, func, operand, input ready);
  modport sink (input valid, func, operand, output ready);
endinterface

interface filsq_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        nonresidue;
  modport source (output valid, value, nonresidue, input ready);
  modport sink (input valid, value, nonresidue, output ready);
endinterface
`default_nettype wire

### rtl/field_inverse_legendre_sqrt_unit.sv
`default_nettype none
// Field helper for p = 2^64-59 in Montgomery form (R = 2^64). One item is worked on at a
// time on one shared bit-serial Montgomery multiplier, which is started once per multiply
// and then steps until done. Inverse and legendre run square-and-multiply over 64 exponent
// bits, one squaring per bit plus one multiply per set bit; square root runs two such
// exponentiations and possibly one more multiply; the conversions take one multiply. The
// result register holds the item until taken, and the next item can be accepted meanwhile.
module field_inverse_legendre_sqrt_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  filsq_in_if.sink   in_ch,
  filsq_out_if.source out_ch
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SQW = 4'd2, S_ML = 4'd3,
                         S_MLW = 4'd4, S_ONE = 4'd5, S_ONEW = 4'd6, S_OUT = 4'd7,
                         S_FIN = 4'd8;

  logic [3:0]  st_r, st_nxt;
  logic [2:0]  fn_r, fn_nxt;
  logic [63:0] a_r, a_nxt, acc_r, acc_nxt, e_r, e_nxt, q_r, q_nxt;
  logic [6:0]  bit_r, bit_nxt;
  logic        pass_r, pass_nxt;
  logic [63:0] val_r, val_nxt;
  logic        nr_r, nr_nxt, ov_r, ov_nxt;
  logic        m_start;
  logic [63:0] m_a, m_b, m_res, opr;
  logic        m_done;
  logic [64:0] dif;

  filsq_mul u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b),
                   .done(m_done), .res(m_res));

  assign dif = {1'b0, in_ch.operand} - {1'b0, filsq_pkg::PRIME};
  assign opr = dif[64] ? in_ch.operand : dif[63:0];
  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.value = val_r;
  assign out_ch.nonresidue = nr_r;

  always_comb begin
    st_nxt = st_r; fn_nxt = fn_r; a_nxt = a_r; acc_nxt = acc_r; e_nxt = e_r;
    q_nxt = q_r; bit_nxt = bit_r; pass_nxt = pass_r; val_nxt = val_r;
    nr_nxt = nr_r; ov_nxt = ov_r; m_start = 1'b0; m_a = acc_r; m_b = acc_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_ch.valid) begin
        fn_nxt = in_ch.func; a_nxt = opr; acc_nxt = filsq_pkg::UNITY_M;
        bit_nxt = 7'd64; pass_nxt = 1'b0;
        case (in_ch.func)
          filsq_pkg::FN_INV:  begin e_nxt = filsq_pkg::EXP_INV; st_nxt = S_SQ; end
          filsq_pkg::FN_LEG:  begin e_nxt = filsq_pkg::EXP_LEG; st_nxt = S_SQ; end
          filsq_pkg::FN_SQRT: begin e_nxt = filsq_pkg::EXP_QUART; st_nxt = S_SQ; end
          filsq_pkg::FN_TOM:  begin acc_nxt = filsq_pkg::MONT_R2; st_nxt = S_ONE; end
          filsq_pkg::FN_FROMM: begin acc_nxt = 64'd1; st_nxt = S_ONE; end
          default: begin acc_nxt = '0; st_nxt = S_OUT; end
        endcase
      end
      S_SQ: begin m_start = 1'b1; st_nxt = S_SQW; end
      S_SQW: if (m_done) begin
        acc_nxt = m_res; st_nxt = e_r[63] ? S_ML : S_FIN;
      end
      S_ML: begin m_start = 1'b1; m_b = a_r; st_nxt = S_MLW; end
      S_MLW: if (m_done) begin acc_nxt = m_res; st_nxt = S_FIN; end
      S_FIN: begin
        e_nxt = {e_r[62:0], 1'b0}; bit_nxt = bit_r - 7'd1;
        if (bit_r != 7'd1) st_nxt = S_SQ;
        else if (fn_r == filsq_pkg::FN_SQRT && !pass_r) begin
          q_nxt = acc_r; pass_nxt = 1'b1; acc_nxt = filsq_pkg::UNITY_M;
          e_nxt = filsq_pkg::EXP_ROOT; bit_nxt = 7'd64; st_nxt = S_SQ;
        end else if (fn_r == filsq_pkg::FN_SQRT && q_r != filsq_pkg::UNITY_M) begin
          a_nxt = filsq_pkg::PSI; st_nxt = S_ONE;
        end else st_nxt = S_OUT;
      end
      S_ONE: begin m_start = 1'b1; m_b = a_r; st_nxt = S_ONEW; end
      S_ONEW: if (m_done) begin acc_nxt = m_res; st_nxt = S_OUT; end
      S_OUT: if (!ov_r) begin
        ov_nxt = 1'b1;
        if (fn_r == filsq_pkg::FN_LEG) begin
          val_nxt = '0; nr_nxt = |(acc_r[7:0] & filsq_pkg::LEG_MASK);
        end else begin
          val_nxt = acc_r; nr_nxt = 1'b0;
        end
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    fn_r <= fn_nxt; a_r <= a_nxt; acc_r <= acc_nxt; e_r <= e_nxt; q_r <= q_nxt;
    bit_r <= bit_nxt; pass_r <= pass_nxt; val_r <= val_nxt; nr_r <= nr_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/filsq_mul.sv
`default_nettype none
module filsq_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire filsq_pkg::elem_t   a,
  input  wire filsq_pkg::elem_t   b,
  output logic                    done,
  output filsq_pkg::elem_t        res
);
  logic [65:0] acc_r, acc_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [65:0] s1, s2;
  logic [64:0] sub;

  always_comb begin
    s1 = acc_r + (a_r[0] ? {2'b00, b_r} : 66'd0);
    s2 = s1 + (s1[0] ? {2'b00, filsq_pkg::PRIME} : 66'd0);
    sub = acc_r[64:0] - {1'b0, filsq_pkg::PRIME};
    acc_nxt = acc_r; a_nxt = a_r; b_nxt = b_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0; a_nxt = a; b_nxt = b; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {1'b0, s2[65:1]};
      a_nxt = {1'b0, a_r[63:1]};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  assign res  = sub[64] ? acc_r[63:0] : sub[63:0];
  assign done = done_r;

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; a_r <= a_nxt; b_r <= b_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/filsq_chk.sv
`default_nettype none
module filsq_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [63:0] out_value,
  input wire logic out_nonresidue
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)) else $error("hold");
  a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("busy");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value < 64'hFFFFFFFFFFFFFFC5) else $error("range");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nonresidue |-> out_value == 64'd0) else $error("leg");
endmodule

bind field_inverse_legendre_sqrt_unit filsq_chk u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_value(out_ch.value), .out_nonresidue(out_ch.nonresidue));
`default_nettype wire

### tb/sv/field_inverse_legendre_sqrt_unit_tb.sv
`default_nettype none
module field_inverse_legendre_sqrt_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]       func;
    filsq_pkg::elem_t operand;
  } request_t;

  typedef struct packed {
    filsq_pkg::elem_t value;
    logic             nonresidue;
  } answer_t;

  logic clk;
  logic rst_n;

  filsq_in_if  in_ch ();
  filsq_out_if out_ch ();

  field_inverse_legendre_sqrt_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  request_t pending_q[$];
  answer_t  answer_q[$];
  int unsigned sent_cnt;
  int unsigned got_cnt;
  int unsigned err_cnt;
  int unsigned func_cnt[8];

  function automatic filsq_pkg::elem_t neg_prime_inv();
    filsq_pkg::elem_t x;
    x = 64'd59;
    for (int i = 0; i < 6; i++) begin
      x = x * (64'd2 - 64'd59 * x);
    end
    return x;
  endfunction

  function automatic filsq_pkg::elem_t field_redc(logic [127:0] t);
    filsq_pkg::elem_t m;
    logic [128:0]     s;
    logic [64:0]      u;
    m = t[63:0] * neg_prime_inv();
    s = {1'b0, t} + m * {64'd0, filsq_pkg::PRIME};
    u = s[128:64];
    if (u >= {1'b0, filsq_pkg::PRIME}) begin
      u = u - {1'b0, filsq_pkg::PRIME};
    end
    return u[63:0];
  endfunction

  function automatic filsq_pkg::elem_t field_mul(filsq_pkg::elem_t a, filsq_pkg::elem_t b);
    return field_redc({64'd0, a} * {64'd0, b});
  endfunction

  function automatic filsq_pkg::elem_t field_pow(filsq_pkg::elem_t a, filsq_pkg::elem_t e);
    filsq_pkg::elem_t acc;
    acc = filsq_pkg::UNITY_M;
    for (int i = 63; i >= 0; i--) begin
      acc = field_mul(acc, acc);
      if (e[i]) begin
        acc = field_mul(acc, a);
      end
    end
    return acc;
  endfunction

  function automatic answer_t predict_field_op(request_t r);
    answer_t          res;
    filsq_pkg::elem_t a;
    filsq_pkg::elem_t quart;
    filsq_pkg::elem_t root;
    filsq_pkg::elem_t leg;
    res = '0;
    a = r.operand;
    if (a >= filsq_pkg::PRIME) begin
      a = a - filsq_pkg::PRIME;
    end
    case (r.func)
      filsq_pkg::FN_INV: begin
        res.value = field_pow(a, filsq_pkg::EXP_INV);
      end
      filsq_pkg::FN_LEG: begin
        leg = field_pow(a, filsq_pkg::EXP_LEG);
        res.nonresidue = |(leg[7:0] & filsq_pkg::LEG_MASK);
      end
      filsq_pkg::FN_SQRT: begin
        quart = field_pow(a, filsq_pkg::EXP_QUART);
        root = field_pow(a, filsq_pkg::EXP_ROOT);
        res.value = (quart == filsq_pkg::UNITY_M) ? root : field_mul(root, filsq_pkg::PSI);
      end
      filsq_pkg::FN_TOM: begin
        res.value = field_mul(a, filsq_pkg::MONT_R2);
      end
      filsq_pkg::FN_FROMM: begin
        res.value = field_redc({64'd0, a});
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    $display("%0t: item %0d %s got %h want %h", $realtime, got_cnt, what, got, want);
  endtask

  function automatic filsq_pkg::elem_t rand_elem();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("Mismatches found");
    $finish;
  end

  wire calm = (sent_cnt >= 400) && (sent_cnt < 560);

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.func    <= '0;
      in_ch.operand <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
        request_t r;
        r = pending_q.pop_front();
        answer_q.push_back(predict_field_op(r));
        func_cnt[r.func]++;
        sent_cnt++;
        in_ch.valid   <= 1'b1;
        in_ch.func    <= r.func;
        in_ch.operand <= r.operand;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 38);
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected", out_ch.value, '0);
        end else begin
          answer_t w;
          w = answer_q.pop_front();
          if (out_ch.value !== w.value) begin
            report_mismatch("value", out_ch.value, w.value);
          end
          if (out_ch.nonresidue !== w.nonresidue) begin
            report_mismatch("nonresidue", {63'd0, out_ch.nonresidue}, {63'd0, w.nonresidue});
          end
        end
        got_cnt++;
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_ch.valid || answer_q.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    filsq_pkg::elem_t corner[6];
    request_t         r;
    rst_n = 1'b0;
    sent_cnt = 0;
    got_cnt = 0;
    err_cnt = 0;
    corner = '{64'd0, filsq_pkg::UNITY_M, filsq_pkg::PRIME - 64'd1, filsq_pkg::PRIME,
               64'hFFFFFFFFFFFFFFFF, filsq_pkg::PSI};
    for (int f = 0; f < 5; f++) begin
      for (int k = 0; k < 6; k++) begin
        if (f >= 3 || k != 5) begin
          r.func = f[2:0];
          r.operand = corner[k];
          pending_q.push_back(r);
        end
      end
    end
    for (int f = 5; f < 8; f++) begin
      r.func = f[2:0];
      r.operand = rand_elem();
      pending_q.push_back(r);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();
    repeat (20) @(posedge clk);
    for (int n = 0; n < 1050; n++) begin
      r.func = 3'($urandom_range(7));
      case ($urandom_range(19))
        0: r.operand = filsq_pkg::PRIME + 64'($urandom_range(58));
        1: r.operand = 64'($urandom_range(255));
        2: r.operand = filsq_pkg::PRIME - 64'd1 - 64'($urandom_range(255));
        default: r.operand = rand_elem();
      endcase
      pending_q.push_back(r);
    end
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Ran %0d items, %0d results: inverse %0d, legendre %0d, sqrt %0d,",
             sent_cnt, got_cnt, func_cnt[0], func_cnt[1], func_cnt[2]);
    $display("  to-mont %0d, from-mont %0d, unused selectors %0d; %0d mismatches",
             func_cnt[3], func_cnt[4], func_cnt[5] + func_cnt[6] + func_cnt[7], err_cnt);
    if (err_cnt == 0 && answer_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
